// ===== rtl/calendar_date_stepper_unit_macros.svh =====
// Assertion macros for the calendar date stepper checker.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef CALENDAR_DATE_STEPPER_UNIT_MACROS_SVH
`define CALENDAR_DATE_STEPPER_UNIT_MACROS_SVH

// Same-cycle implication, reset masked
`define CDS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, reset masked
`define CDS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cdsu_pkg.sv =====
// Shared types, constants and calendar helpers for the date stepper.
// No dependencies.
package cdsu_pkg;

    // Field widths
    localparam int MODE_W  = 3;
    localparam int VALUE_W = 14;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int CENT_W  = 7;
    localparam int YY_W    = 7;

    // Year range
    localparam int YEAR_BITS  = 14;
    localparam int YEAR_CAP   = 9999;
    localparam int YEAR_MAX   = (((1 << YEAR_BITS) - 1) < YEAR_CAP) ?
                                ((1 << YEAR_BITS) - 1) : YEAR_CAP;
    localparam int FIRST_YEAR = 1900;
    localparam int MIN_SET_YEAR_RST = 1918;

    // Divide-by-100 via reciprocal: exact for values below 43690
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_MUL_W = 13;
    localparam int DIV100_SHIFT = 19;
    localparam int QUOT_W       = 8;
    localparam int PROD_W       = VALUE_W + DIV100_MUL_W;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_INC_DAY   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DEC_DAY   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SET_YEAR  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SET_MONTH = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SET_DAY   = 3'd4;

    // Month codes used by the logic
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_MIN_SET_YEAR = '0;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  cur_year;
        logic [MONTH_W-1:0] cur_month;
        logic [DAY_W-1:0]   cur_day;
        logic               leap_year;
        logic               accepted;
    } rsp_t;

    // Days in a month; months outside 1..12 give zero
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] n;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
            4'd2:                                       n = leap ? 5'd29 : 5'd28;
            default:                                    n = 5'd0;
        endcase
        return n;
    endfunction

    // Leap rule on a year held as century and year-of-century
    function automatic logic leap_of(input logic [CENT_W-1:0] cent,
                                     input logic [YY_W-1:0] yy);
        return (yy == '0) ? (cent[1:0] == 2'b00) : (yy[1:0] == 2'b00);
    endfunction

endpackage

// ===== rtl/calendar_date_stepper_unit.sv =====
// Calendar date stepper: Gregorian date register with day steps and set requests.
// Each request goes through the input register, then the response register.
// One request per cycle while rsp_stall is low, via a combinational date update.
// The year is kept both in binary and split as century / year-of-century for the leap rule.
// Reset (rst_n low, async) gives 1900-01-01, min_set_year = 1918, both stages empty.
// Depends on cdsu_pkg.
module calendar_date_stepper_unit
    import cdsu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req_beat,
    // response channel
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp_beat,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [VALUE_W-1:0] FIRST_YEAR_V = VALUE_W'(FIRST_YEAR);
    localparam logic [VALUE_W-1:0] YEAR_MAX_V   = VALUE_W'(YEAR_MAX);
    localparam logic [VALUE_W-1:0] MONTH_MAX_V  = VALUE_W'(12);
    localparam logic [YY_W-1:0]    YY_LAST      = YY_W'(99);

    // Config register
    logic [VALUE_W-1:0] min_set_year_reg;
    logic               cfg_wr;
    logic               cfg_hit;

    // Input stage
    logic                s1_valid_reg;
    logic [MODE_W-1:0]   s1_mode_reg;
    logic [VALUE_W-1:0]  s1_value_reg;
    logic [QUOT_W-1:0]   s1_quot_reg;
    logic [PROD_W-1:0]   quot_prod;
    logic                req_take;
    logic                advance;

    // Date state
    logic [YEAR_W-1:0]   year_reg,  year_next;
    logic [CENT_W-1:0]   cent_reg,  cent_next;
    logic [YY_W-1:0]     yy_reg,    yy_next;
    logic [MONTH_W-1:0]  month_reg, month_next;
    logic [DAY_W-1:0]    day_reg,   day_next;
    logic                ok;

    // Output stage
    logic                rsp_valid_reg;
    rsp_t                rsp_beat_reg;

    // Update helpers
    logic                cur_leap;
    logic [DAY_W-1:0]    cur_dim;
    logic [MONTH_W-1:0]  month_dec;
    logic [VALUE_W-1:0]  hundreds;
    logic [VALUE_W-1:0]  set_rem;

    // Register port: always ready, word index taken from paddr
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[APB_ADDR_W-1:2] == REG_MIN_SET_YEAR);
    assign cfg_wr  = psel && penable && pwrite && cfg_hit;
    assign prdata  = cfg_hit ? APB_DATA_W'(min_set_year_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_set_year_reg <= VALUE_W'(MIN_SET_YEAR_RST);
        end
        else if (cfg_wr)
        begin
            min_set_year_reg <= pwdata[VALUE_W-1:0];
        end
    end

    // Handshake: input stage moves when the output slot is free or draining
    assign advance   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !advance;
    assign req_take  = req_valid && !req_stall;

    // Quotient by 100 for set-year, computed on the way in
    assign quot_prod = PROD_W'(req_beat.value) * PROD_W'(DIV100_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            s1_mode_reg  <= req_beat.mode;
            s1_value_reg <= req_beat.value;
            s1_quot_reg  <= quot_prod[DIV100_SHIFT +: QUOT_W];
        end
    end

    // Current month length
    assign cur_leap  = leap_of(cent_reg, yy_reg);
    assign cur_dim   = month_days(month_reg, cur_leap);
    assign month_dec = month_reg - MONTH_W'(1);

    // Year-of-century for a set-year value: value - 100 * quotient
    assign hundreds = VALUE_W'({s1_quot_reg, 6'b0}) + VALUE_W'({s1_quot_reg, 5'b0})
                    + VALUE_W'({s1_quot_reg, 2'b0});
    assign set_rem  = s1_value_reg - hundreds;

    // Date update
    always_comb
    begin
        year_next  = year_reg;
        cent_next  = cent_reg;
        yy_next    = yy_reg;
        month_next = month_reg;
        day_next   = day_reg;
        ok         = 1'b0;
        case (s1_mode_reg)
            MODE_INC_DAY:
            begin
                if (day_reg >= cur_dim)
                begin
                    if (month_reg >= MONTH_DEC)
                    begin
                        if (VALUE_W'(year_reg) < YEAR_MAX_V)
                        begin
                            year_next  = year_reg + YEAR_W'(1);
                            if (yy_reg == YY_LAST)
                            begin
                                yy_next   = '0;
                                cent_next = cent_reg + CENT_W'(1);
                            end
                            else
                            begin
                                yy_next = yy_reg + YY_W'(1);
                            end
                            month_next = MONTH_JAN;
                            day_next   = DAY_W'(1);
                            ok         = 1'b1;
                        end
                    end
                    else
                    begin
                        month_next = month_reg + MONTH_W'(1);
                        day_next   = DAY_W'(1);
                        ok         = 1'b1;
                    end
                end
                else
                begin
                    day_next = day_reg + DAY_W'(1);
                    ok       = 1'b1;
                end
            end
            MODE_DEC_DAY:
            begin
                if (day_reg > DAY_W'(1))
                begin
                    day_next = day_reg - DAY_W'(1);
                    ok       = 1'b1;
                end
                else if (month_reg > MONTH_JAN)
                begin
                    month_next = month_dec;
                    day_next   = month_days(month_dec, cur_leap);
                    ok         = 1'b1;
                end
                else if (VALUE_W'(year_reg) > FIRST_YEAR_V)
                begin
                    year_next = year_reg - YEAR_W'(1);
                    if (yy_reg == '0)
                    begin
                        yy_next   = YY_LAST;
                        cent_next = cent_reg - CENT_W'(1);
                    end
                    else
                    begin
                        yy_next = yy_reg - YY_W'(1);
                    end
                    month_next = MONTH_DEC;
                    day_next   = DAY_W'(31);
                    ok         = 1'b1;
                end
            end
            MODE_SET_YEAR:
            begin
                if (s1_value_reg >= min_set_year_reg && s1_value_reg >= FIRST_YEAR_V
                    && s1_value_reg <= YEAR_MAX_V)
                begin
                    year_next = YEAR_W'(s1_value_reg);
                    cent_next = s1_quot_reg[CENT_W-1:0];
                    yy_next   = set_rem[YY_W-1:0];
                    ok        = 1'b1;
                end
            end
            MODE_SET_MONTH:
            begin
                if (s1_value_reg >= VALUE_W'(1) && s1_value_reg <= MONTH_MAX_V)
                begin
                    month_next = s1_value_reg[MONTH_W-1:0];
                    ok         = 1'b1;
                end
            end
            MODE_SET_DAY:
            begin
                if (s1_value_reg >= VALUE_W'(1) && s1_value_reg <= VALUE_W'(cur_dim))
                begin
                    day_next = s1_value_reg[DAY_W-1:0];
                    ok       = 1'b1;
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // Date state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg  <= YEAR_W'(FIRST_YEAR);
            cent_reg  <= CENT_W'(FIRST_YEAR / 100);
            yy_reg    <= YY_W'(FIRST_YEAR % 100);
            month_reg <= MONTH_JAN;
            day_reg   <= DAY_W'(1);
        end
        else if (advance)
        begin
            year_reg  <= year_next;
            cent_reg  <= cent_next;
            yy_reg    <= yy_next;
            month_reg <= month_next;
            day_reg   <= day_next;
        end
    end

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_beat_reg.cur_year  <= year_next;
            rsp_beat_reg.cur_month <= month_next;
            rsp_beat_reg.cur_day   <= day_next;
            rsp_beat_reg.leap_year <= leap_of(cent_next, yy_next);
            rsp_beat_reg.accepted  <= ok;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_beat  = rsp_beat_reg;

endmodule

// ===== rtl/cdsu_checker.sv =====
// Port-level checker for the calendar date stepper, bound into calendar_date_stepper_unit.
// Depends on cdsu_pkg and calendar_date_stepper_unit_macros.svh.
`include "calendar_date_stepper_unit_macros.svh"

module cdsu_checker
    import cdsu_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp_beat
);

    // A stalled response beat holds
    `CDS_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_beat), "response beat changed while stalled")

    // Month always in range
    `CDS_ASSERT_IMP(a_month_range, rsp_valid, rsp_beat.cur_month >= MONTH_JAN && rsp_beat.cur_month <= MONTH_DEC, "month out of range")

    // Day never zero
    `CDS_ASSERT_IMP(a_day_nonzero, rsp_valid, rsp_beat.cur_day != '0, "day is zero")

    // Year never below the first year
    `CDS_ASSERT_IMP(a_year_floor, rsp_valid, rsp_beat.cur_year >= YEAR_W'(FIRST_YEAR), "year below first year")

endmodule

bind calendar_date_stepper_unit cdsu_checker u_cdsu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_beat  (rsp_beat)
);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for calendar_date_stepper_unit: predicts every response beat.
// Depends on cdsu_pkg and the calendar_date_stepper_unit RTL.
module tb;
    import cdsu_pkg::*;

    localparam int          NUM_PHASES      = 8;
    localparam int unsigned ITEMS_PER_PHASE = 160;
    localparam int          PIPE_SLACK      = 6;
    localparam int          QUIET_LIMIT     = 4000;
    localparam int unsigned VALUE_MAX       = (1 << VALUE_W) - 1;

    // Mode codes the block leaves unused
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    req_t                  req_beat  = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_t                  rsp_beat;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Request beats waiting to be driven, and responses still owed by the block
    req_t req_backlog[$];
    rsp_t due_dates[$];

    // Predicted calendar state and register copy
    int unsigned cal_year     = FIRST_YEAR;
    int unsigned cal_month    = 1;
    int unsigned cal_day      = 1;
    int unsigned min_year_cfg = MIN_SET_YEAR_RST;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int          errors        = 0;
    int          quiet_cycles  = 0;

    calendar_date_stepper_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_beat  (req_beat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_beat  (rsp_beat),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Gregorian leap rule
    function automatic bit leap_rule(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_rule(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // Apply one request to the predicted date and build the response it should give
    function automatic rsp_t advance_calendar(input req_t r);
        rsp_t        o;
        bit          applied;
        int unsigned v;
        applied = 1'b0;
        v = 32'(r.value);
        case (r.mode)
            MODE_INC_DAY:
                if (cal_day + 1 > month_length(cal_year, cal_month))
                begin
                    if (cal_month >= 32'(MONTH_DEC))
                    begin
                        // hold on the last day of the last year
                        if (cal_year < YEAR_MAX)
                        begin
                            cal_year  = cal_year + 1;
                            cal_month = 32'(MONTH_JAN);
                            cal_day   = 1;
                            applied   = 1'b1;
                        end
                    end
                    else
                    begin
                        cal_month = cal_month + 1;
                        cal_day   = 1;
                        applied   = 1'b1;
                    end
                end
                else
                begin
                    cal_day = cal_day + 1;
                    applied = 1'b1;
                end
            MODE_DEC_DAY:
                if (cal_day > 1)
                begin
                    cal_day = cal_day - 1;
                    applied = 1'b1;
                end
                else if (cal_month > 32'(MONTH_JAN))
                begin
                    cal_month = cal_month - 1;
                    cal_day   = month_length(cal_year, cal_month);
                    applied   = 1'b1;
                end
                else if (cal_year > FIRST_YEAR)
                begin
                    cal_year  = cal_year - 1;
                    cal_month = 32'(MONTH_DEC);
                    cal_day   = 31;
                    applied   = 1'b1;
                end
            MODE_SET_YEAR:
                if (v >= min_year_cfg && v >= FIRST_YEAR && v <= YEAR_MAX)
                begin
                    cal_year = v;
                    applied  = 1'b1;
                end
            MODE_SET_MONTH:
                if (v >= 1 && v <= 12)
                begin
                    cal_month = v;
                    applied   = 1'b1;
                end
            MODE_SET_DAY:
                if (v >= 1 && v <= month_length(cal_year, cal_month))
                begin
                    cal_day = v;
                    applied = 1'b1;
                end
            default: ;
        endcase
        o.cur_year  = cal_year[YEAR_W-1:0];
        o.cur_month = cal_month[MONTH_W-1:0];
        o.cur_day   = cal_day[DAY_W-1:0];
        o.leap_year = leap_rule(cal_year);
        o.accepted  = applied;
        return o;
    endfunction

    function automatic void queue_req(input logic [MODE_W-1:0] mode, input int unsigned value);
        req_t r;
        r.mode  = mode;
        r.value = value[VALUE_W-1:0];
        req_backlog.push_back(r);
    endfunction

    // Set a date near an interesting boundary, then walk from it day by day
    function automatic int unsigned queue_date_walk();
        int unsigned lo;
        int unsigned yr;
        int unsigned steps;
        bit          fwd;
        lo = (min_year_cfg > FIRST_YEAR) ? min_year_cfg : FIRST_YEAR;
        case ($urandom_range(5))
            0:       yr = lo;
            1:       yr = YEAR_MAX;
            2:       yr = $urandom_range(19, 99) * 100;
            3:       yr = $urandom_range(lo, YEAR_MAX) & ~32'd3;
            default: yr = $urandom_range(lo, YEAR_MAX);
        endcase
        queue_req(MODE_SET_YEAR, yr);
        if ($urandom_range(99) < 40)
            queue_req(MODE_SET_MONTH, $urandom_range(1) ? 32'(MONTH_DEC) : 32'(MONTH_FEB));
        else
            queue_req(MODE_SET_MONTH, $urandom_range(1, 12));
        if ($urandom_range(1))
            queue_req(MODE_SET_DAY, $urandom_range(27, 31));
        else
            queue_req(MODE_SET_DAY, $urandom_range(1, 31));
        steps = ($urandom_range(99) < 30) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        fwd = ($urandom_range(99) < 60);
        for (int i = 0; i < steps; i++)
            queue_req((fwd ^ ($urandom_range(99) < 15)) ? MODE_INC_DAY : MODE_DEC_DAY,
                      $urandom_range(VALUE_MAX));
        return steps + 3;
    endfunction

    // Wait until no beat is pending, on the wire or owed back
    task automatic await_quiet();
        do
            @(negedge clk);
        while (req_backlog.size() != 0 || req_valid || due_dates.size() != 0);
    endtask

    // APB write of min_set_year: setup cycle, then access cycle
    task automatic write_min_year(input int unsigned yr);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MIN_SET_YEAR, 2'b00};
        pwdata  <= yr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        min_year_cfg = yr & VALUE_MAX;
        @(negedge clk);
    endtask

    // Request driver: next beat only once the current one is taken
    always @(posedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || !req_stall)
        begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req_beat  <= req_backlog.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Response backpressure
    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    task automatic check_field(input string what, input int unsigned want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // Monitor: predict on request beats, compare on response beats
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                due_dates.push_back(advance_calendar(req_beat));
            if (rsp_valid === 1'b1 && !rsp_stall)
            begin
                if (due_dates.size() == 0)
                begin
                    $display("%0t: unexpected response beat, expected none actual %h",
                             $time, rsp_beat);
                    errors++;
                end
                else
                begin
                    want = due_dates.pop_front();
                    check_field("cur_year",  32'(want.cur_year),  32'(rsp_beat.cur_year));
                    check_field("cur_month", 32'(want.cur_month), 32'(rsp_beat.cur_month));
                    check_field("cur_day",   32'(want.cur_day),   32'(rsp_beat.cur_day));
                    check_field("leap_year", 32'(want.leap_year), 32'(rsp_beat.leap_year));
                    check_field("accepted",  32'(want.accepted),  32'(rsp_beat.accepted));
                end
            end
        end
    end

    // Watchdog on cycles with no beat and no register access
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned floor_year;
        int unsigned pushed;
        bit          paused;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph > 0)
            begin
                await_quiet();
                repeat (PIPE_SLACK) @(negedge clk);
                case (ph)
                    1:       floor_year = 1;
                    2:       floor_year = YEAR_CAP;
                    3:       floor_year = FIRST_YEAR;
                    default: floor_year = $urandom_range(1, YEAR_CAP);
                endcase
                write_min_year(floor_year);
                // just below and at the new floor
                queue_req(MODE_SET_YEAR, floor_year - 1);
                queue_req(MODE_SET_YEAR, floor_year);
            end
            else
            begin
                // directed: first date, last date, range checks, day left past month end
                queue_req(MODE_DEC_DAY, 0);
                queue_req(MODE_INC_DAY, VALUE_MAX);
                queue_req(MODE_DEC_DAY, 0);
                queue_req(MODE_SET_YEAR, min_year_cfg - 1);
                queue_req(MODE_SET_YEAR, VALUE_MAX);
                queue_req(MODE_SET_YEAR, 0);
                queue_req(MODE_SET_YEAR, YEAR_MAX);
                queue_req(MODE_SET_MONTH, 32'(MONTH_DEC));
                queue_req(MODE_SET_DAY, 31);
                queue_req(MODE_INC_DAY, 0);
                queue_req(MODE_SET_MONTH, 0);
                queue_req(MODE_SET_MONTH, 13);
                queue_req(MODE_SET_DAY, 0);
                queue_req(MODE_SET_DAY, 32);
                queue_req(MODE_SET_MONTH, 32'(MONTH_JAN));
                queue_req(MODE_SET_DAY, 31);
                queue_req(MODE_SET_YEAR, 2000);
                queue_req(MODE_SET_MONTH, 32'(MONTH_FEB));
                queue_req(MODE_DEC_DAY, 0);
                queue_req(MODE_INC_DAY, 0);
                queue_req(MODE_SET_MONTH, 32'(MONTH_FEB));
                queue_req(MODE_SET_DAY, 29);
                queue_req(MODE_SET_YEAR, 2100);
                queue_req(MODE_SET_DAY, 29);
                queue_req(MODE_INC_DAY, 0);
                queue_req(MODE_SPARE_LO, VALUE_MAX);
                queue_req(MODE_SPARE_HI, 0);
            end

            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 79;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 79;
                end
                default:
                begin
                    send_idle_pct = 9;
                    stall_pct     = 9;
                end
            endcase

            // mostly date walks, the rest arbitrary mode and value
            pushed = 0;
            paused = 1'b0;
            while (pushed < ITEMS_PER_PHASE)
            begin
                if (!paused && pushed >= ITEMS_PER_PHASE / 2)
                begin
                    // hold off until the block has answered everything
                    await_quiet();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 75)
                    pushed += queue_date_walk();
                else
                begin
                    queue_req(MODE_W'($urandom_range(MODE_SPARE_HI)),
                              $urandom_range(1) ? $urandom_range(VALUE_MAX)
                                                : $urandom_range(40));
                    pushed++;
                end
            end
        end

        await_quiet();
        repeat (PIPE_SLACK) @(negedge clk);
        if (errors == 0 && due_dates.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cdsu_pkg.sv
rtl/calendar_date_stepper_unit.sv
rtl/cdsu_checker.sv
dv/tb.sv
